// ----- rtl/core/alp_pkg.sv -----
// shared types and constants for the positional linked-list block
// no dependencies; used by alp_node_store, alp_ctrl and array_linked_list_positional
package alp_pkg;

    localparam logic [7:0] NULL_LINK = 8'hFF;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // node store access from the controller, indexes are link-wide
    typedef struct packed {
        logic [7:0]  link_raddr;
        logic        link_we;
        logic [7:0]  link_waddr;
        logic [7:0]  link_wdata;
        logic [7:0]  val_raddr;
        logic        val_we;
        logic [7:0]  val_waddr;
        logic [31:0] val_wdata;
    } mem_req_t;

    typedef struct packed {
        logic        is_empty;
        logic [7:0]  list_length;
        logic [31:0] read_value;
        logic [1:0]  status;
    } res_t;

endpackage

// ----- rtl/core/array_linked_list_positional.sv -----
// top level of the positional linked list: stream ports, result register
// instantiates alp_ctrl and alp_node_store; depends on alp_pkg
//
// ordered list of 32-bit words held in a store of CAPACITY nodes, with unused nodes
// chained as a free list. one transfer in gives exactly one transfer out. an insert
// puts the word at a 1-based position, a read returns the word at a position; status
// reports ok, invalid position or store full, and a failed item leaves the list as it
// was. every result carries the length and an empty flag after the item. items are
// handled one at a time: the sequencer follows one link per cycle through the link
// memory, whose reads are registered, so the walk grows with the position of the item,
// and a range or full error skips the walk entirely. the result sits in an output
// register, so the next item is taken while a result waits; it only stalls at
// completion until that register frees up. no clearing pass is needed after reset:
// the link memory keeps a valid bit per entry.
module array_linked_list_positional #(
    parameter int CAPACITY = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[7:0], value[39:8]
    input  logic [0:0]  s_tuser,   // op[0]: insert or read
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], read_value[33:2], list_length[41:34],
                                   // is_empty[42], zero[47:43]
);

    alp_pkg::mem_req_t req;
    alp_pkg::res_t     res;
    logic [7:0]        link_rdata;
    logic [31:0]       val_rdata;
    logic              res_valid;
    logic              res_ready;

    logic              m_tvalid_reg;
    logic [47:0]       m_tdata_reg;

    alp_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser[0]),
        .in_pos    (s_tdata[7:0]),
        .in_val    (s_tdata[39:8]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .req       (req),
        .link_rdata(link_rdata),
        .val_rdata (val_rdata)
    );

    alp_node_store #(
        .CAPACITY(CAPACITY)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .link_rdata(link_rdata),
        .val_rdata (val_rdata)
    );

    // output register frees when empty or being taken this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_tdata_reg <= {5'd0, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/alp_node_store.sv -----
// node store: link memory with per-entry valid bits and value memory
// both reads registered; depends on alp_pkg
module alp_node_store #(
    parameter int CAPACITY = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  alp_pkg::mem_req_t req,
    output logic [7:0]        link_rdata,
    output logic [31:0]       val_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);

    logic [7:0]          link_mem [CAPACITY];
    logic [31:0]         val_mem  [CAPACITY];
    logic [CAPACITY-1:0] link_vld_reg;
    logic [7:0]          link_rdata_reg;
    logic [31:0]         val_rdata_reg;

    logic [AW-1:0] link_ra;
    logic [AW-1:0] link_wa;
    logic [AW-1:0] val_ra;
    logic [AW-1:0] val_wa;
    logic [7:0]    link_dflt;

    assign link_ra = req.link_raddr[AW-1:0];
    assign link_wa = req.link_waddr[AW-1:0];
    assign val_ra  = req.val_raddr[AW-1:0];
    assign val_wa  = req.val_waddr[AW-1:0];

    // unwritten entries read as the initial free chain
    assign link_dflt = (link_ra == LAST_IDX) ? alp_pkg::NULL_LINK : 8'(link_ra) + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (req.link_we) begin
            link_vld_reg[link_wa] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.link_we) begin
            link_mem[link_wa] <= req.link_wdata;
        end
        link_rdata_reg <= link_vld_reg[link_ra] ? link_mem[link_ra] : link_dflt;
    end

    always_ff @(posedge aclk) begin
        if (req.val_we) begin
            val_mem[val_wa] <= req.val_wdata;
        end
        val_rdata_reg <= val_mem[val_ra];
    end

    assign link_rdata = link_rdata_reg;
    assign val_rdata  = val_rdata_reg;

endmodule

// ----- rtl/core/alp_ctrl.sv -----
// list sequencer: range checks, link walk, free-list pop and splice
// drives alp_node_store through alp_pkg::mem_req_t; depends on alp_pkg
module alp_ctrl #(
    parameter int CAPACITY = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_op,
    input  logic [7:0]        in_pos,
    input  logic [31:0]       in_val,
    output logic              res_valid,
    input  logic              res_ready,
    output alp_pkg::res_t     res,
    output alp_pkg::mem_req_t req,
    input  logic [7:0]        link_rdata,
    input  logic [31:0]       val_rdata
);

    localparam logic [7:0] CAP8 = 8'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_WALK, S_FETCH, S_FETCH_WAIT, S_PRED_WAIT, S_SPLICE, S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic        op_reg, op_next;
    logic [7:0]  pos_reg, pos_next;
    logic [31:0] val_reg, val_next;
    logic [7:0]  steps_reg, steps_next;
    logic [7:0]  cur_reg, cur_next;
    logic [7:0]  nfree_reg, nfree_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] rdval_reg, rdval_next;
    logic [7:0]  head_reg, head_next;
    logic [7:0]  free_reg, free_next;
    logic [7:0]  len_reg, len_next;

    logic [7:0] head_safe;
    logic [7:0] link_safe;
    logic [7:0] walk_steps;
    logic       ins_bad_pos;
    logic       rd_bad_pos;
    logic       store_full;

    assign head_safe   = (head_reg < CAP8) ? head_reg : 8'd0;
    assign link_safe   = (link_rdata < CAP8) ? link_rdata : 8'd0;
    assign ins_bad_pos = (pos_reg == 8'd0) || ({1'b0, pos_reg} > ({1'b0, len_reg} + 9'd1));
    assign rd_bad_pos  = (pos_reg == 8'd0) || (pos_reg > len_reg);
    assign store_full  = (free_reg == alp_pkg::NULL_LINK) || (free_reg >= CAP8);
    // insert walks to the predecessor, read walks to the node itself
    assign walk_steps  = (op_reg == alp_pkg::OP_READ) ? pos_reg - 8'd1 :
                         (pos_reg == 8'd1) ? 8'd0 : pos_reg - 8'd2;

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        steps_next  = steps_reg;
        cur_next    = cur_reg;
        nfree_next  = nfree_reg;
        status_next = status_reg;
        rdval_next  = rdval_reg;
        head_next   = head_reg;
        free_next   = free_reg;
        len_next    = len_reg;
        req         = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                // no transfer is taken while reset is held
                in_ready = aresetn;
                if (in_valid) begin
                    op_next    = in_op;
                    pos_next   = in_pos;
                    val_next   = in_val;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                rdval_next  = '0;
                status_next = alp_pkg::ST_OK;
                cur_next    = head_safe;
                if ((op_reg == alp_pkg::OP_INSERT) && ins_bad_pos) begin
                    status_next = alp_pkg::ST_INVALID;
                    state_next  = S_DONE;
                end else if ((op_reg == alp_pkg::OP_INSERT) && store_full) begin
                    status_next = alp_pkg::ST_FULL;
                    state_next  = S_DONE;
                end else if ((op_reg == alp_pkg::OP_READ) && rd_bad_pos) begin
                    status_next = alp_pkg::ST_INVALID;
                    state_next  = S_DONE;
                end else if (walk_steps == 8'd0) begin
                    state_next = S_FETCH;
                end else begin
                    req.link_raddr = head_safe;
                    steps_next     = walk_steps;
                    state_next     = S_WALK;
                end
            end
            S_WALK: begin
                // one link per cycle, the read data addresses the next read
                steps_next = steps_reg - 8'd1;
                if (steps_reg == 8'd1) begin
                    cur_next   = link_safe;
                    state_next = S_FETCH;
                end else begin
                    req.link_raddr = link_safe;
                end
            end
            S_FETCH: begin
                req.val_raddr  = cur_reg;
                req.link_raddr = free_reg;
                state_next     = S_FETCH_WAIT;
            end
            S_FETCH_WAIT: begin
                if (op_reg == alp_pkg::OP_READ) begin
                    rdval_next = val_rdata;
                    state_next = S_DONE;
                end else begin
                    nfree_next    = link_rdata;
                    req.val_we    = 1'b1;
                    req.val_waddr = free_reg;
                    req.val_wdata = val_reg;
                    if (pos_reg == 8'd1) begin
                        req.link_we    = 1'b1;
                        req.link_waddr = free_reg;
                        req.link_wdata = head_reg;
                        head_next      = free_reg;
                        free_next      = link_rdata;
                        len_next       = len_reg + 8'd1;
                        state_next     = S_DONE;
                    end else begin
                        req.link_raddr = cur_reg;
                        state_next     = S_PRED_WAIT;
                    end
                end
            end
            S_PRED_WAIT: begin
                req.link_we    = 1'b1;
                req.link_waddr = free_reg;
                req.link_wdata = link_rdata;
                state_next     = S_SPLICE;
            end
            S_SPLICE: begin
                req.link_we    = 1'b1;
                req.link_waddr = cur_reg;
                req.link_wdata = free_reg;
                free_next      = nfree_reg;
                len_next       = len_reg + 8'd1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.read_value  = rdval_reg;
    assign res.list_length = len_reg;
    assign res.is_empty    = (len_reg == 8'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= alp_pkg::NULL_LINK;
            free_reg  <= 8'd0;
            len_reg   <= 8'd0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            len_reg   <= len_next;
        end
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        steps_reg  <= steps_next;
        cur_reg    <= cur_next;
        nfree_reg  <= nfree_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= CAP8)
        else $error("list length above capacity");

    a_full_no_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == CAP8) |-> (free_reg == alp_pkg::NULL_LINK))
        else $error("free list not empty with full store");

    a_free_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_reg != alp_pkg::NULL_LINK) |-> (free_reg < CAP8))
        else $error("free head out of range");

    a_head_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == 8'd0) == (head_reg == alp_pkg::NULL_LINK))
        else $error("head and length disagree");

endmodule
